// File: rtl/core/meg_pkg.sv
// meg_pkg: shared types and constants for the midpoint ellipse generator
// holds opcode codes, term widths, controller states, datapath operations
// no dependencies; compile first
package meg_pkg;

    // decision and step terms wrap at this width
    localparam int TERM_BITS = 40;
    // products are kept two bits wider so a quarter-unit value can be floored
    localparam int PROD_BITS = TERM_BITS + 2;

    // input opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // controller states; the first three are the idle regions
    typedef enum logic [3:0] {
        ST_DONE,
        ST_REGION1,
        ST_REGION2,
        ST_START_KEEP,
        ST_START_MUL,
        ST_START_FIN,
        ST_SWITCH_SQ,
        ST_SWITCH_MUL,
        ST_SWITCH_LOAD,
        ST_SWITCH_STEP
    } ctrl_state_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_HOLD,
        DP_LOAD,
        DP_KEEP_SQ,
        DP_INIT_MUL,
        DP_INIT_FIN,
        DP_SW_SQ,
        DP_SW_MUL,
        DP_SW_LOAD,
        DP_STEP1,
        DP_STEP2
    } dp_op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic term_less;   // x_term below y_term, region 1 continues
        logic last_point;  // offset_y is zero after the current operation
    } dp_status_t;

    // result register control from the controller
    typedef struct packed {
        logic emit;
        logic points_valid;
        logic done;
    } emit_ctl_t;

endpackage

// File: rtl/core/meg_if.sv
// meg_if: valid/ready channel interfaces for the ellipse generator
// meg_item_if carries start/advance items, meg_result_if carries point sets
// no package dependency; widths come from interface parameters
interface meg_item_if #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (output valid, opcode, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink (input valid, opcode, center_x, center_y, radius_x, radius_y,
                  output ready);
endinterface

interface meg_result_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] east_south_x;
    logic signed [COORD_BITS+1:0] east_south_y;
    logic signed [COORD_BITS+1:0] west_south_x;
    logic signed [COORD_BITS+1:0] west_south_y;
    logic signed [COORD_BITS+1:0] east_north_x;
    logic signed [COORD_BITS+1:0] east_north_y;
    logic signed [COORD_BITS+1:0] west_north_x;
    logic signed [COORD_BITS+1:0] west_north_y;
    logic                         points_valid;
    logic                         done_res;

    modport source (output valid, east_south_x, east_south_y, west_south_x, west_south_y,
                    east_north_x, east_north_y, west_north_x, west_north_y,
                    points_valid, done_res,
                    input ready);
    modport sink (input valid, east_south_x, east_south_y, west_south_x, west_south_y,
                  east_north_x, east_north_y, west_north_x, west_north_y,
                  points_valid, done_res,
                  output ready);
endinterface

// File: rtl/core/meg_ctrl.sv
// meg_ctrl: region state machine of the ellipse generator
// sequences start setup, region switch and the region-1 and region-2 steps
// depends on meg_pkg
module meg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 in_opcode,
    input  meg_pkg::dp_status_t  status,
    output logic                 idle,
    output meg_pkg::dp_op_t      op,
    output meg_pkg::emit_ctl_t   emit_ctl
);

    meg_pkg::ctrl_state_t state_reg;
    meg_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= meg_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            meg_pkg::ST_DONE, meg_pkg::ST_REGION1, meg_pkg::ST_REGION2:
            begin
                if (in_fire)
                begin
                    if (in_opcode == meg_pkg::OP_START)
                    begin
                        state_next = meg_pkg::ST_START_KEEP;
                    end
                    else if (state_reg == meg_pkg::ST_REGION1)
                    begin
                        if (status.term_less)
                        begin
                            state_next = status.last_point ? meg_pkg::ST_DONE
                                                           : meg_pkg::ST_REGION1;
                        end
                        else
                        begin
                            state_next = meg_pkg::ST_SWITCH_SQ;
                        end
                    end
                    else if (state_reg == meg_pkg::ST_REGION2)
                    begin
                        state_next = status.last_point ? meg_pkg::ST_DONE
                                                       : meg_pkg::ST_REGION2;
                    end
                    else
                    begin
                        state_next = meg_pkg::ST_DONE;
                    end
                end
            end
            meg_pkg::ST_START_KEEP:  state_next = meg_pkg::ST_START_MUL;
            meg_pkg::ST_START_MUL:   state_next = meg_pkg::ST_START_FIN;
            meg_pkg::ST_START_FIN:
            begin
                state_next = status.last_point ? meg_pkg::ST_DONE : meg_pkg::ST_REGION1;
            end
            meg_pkg::ST_SWITCH_SQ:   state_next = meg_pkg::ST_SWITCH_MUL;
            meg_pkg::ST_SWITCH_MUL:  state_next = meg_pkg::ST_SWITCH_LOAD;
            meg_pkg::ST_SWITCH_LOAD: state_next = meg_pkg::ST_SWITCH_STEP;
            meg_pkg::ST_SWITCH_STEP:
            begin
                state_next = status.last_point ? meg_pkg::ST_DONE : meg_pkg::ST_REGION2;
            end
            default: state_next = meg_pkg::ST_DONE;
        endcase
    end

    // datapath operation and result control
    always_comb
    begin
        idle     = 1'b0;
        op       = meg_pkg::DP_HOLD;
        emit_ctl = '0;
        case (state_reg)
            meg_pkg::ST_DONE, meg_pkg::ST_REGION1, meg_pkg::ST_REGION2:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    if (in_opcode == meg_pkg::OP_START)
                    begin
                        op = meg_pkg::DP_LOAD;
                    end
                    else if (state_reg == meg_pkg::ST_REGION1)
                    begin
                        if (status.term_less)
                        begin
                            op                    = meg_pkg::DP_STEP1;
                            emit_ctl.emit         = 1'b1;
                            emit_ctl.points_valid = 1'b1;
                            emit_ctl.done         = status.last_point;
                        end
                    end
                    else if (state_reg == meg_pkg::ST_REGION2)
                    begin
                        op                    = meg_pkg::DP_STEP2;
                        emit_ctl.emit         = 1'b1;
                        emit_ctl.points_valid = 1'b1;
                        emit_ctl.done         = status.last_point;
                    end
                    else
                    begin
                        // advance with nothing left to draw
                        emit_ctl.emit = 1'b1;
                        emit_ctl.done = 1'b1;
                    end
                end
            end
            meg_pkg::ST_START_KEEP:  op = meg_pkg::DP_KEEP_SQ;
            meg_pkg::ST_START_MUL:   op = meg_pkg::DP_INIT_MUL;
            meg_pkg::ST_START_FIN:
            begin
                op                    = meg_pkg::DP_INIT_FIN;
                emit_ctl.emit         = 1'b1;
                emit_ctl.points_valid = 1'b1;
                emit_ctl.done         = status.last_point;
            end
            meg_pkg::ST_SWITCH_SQ:   op = meg_pkg::DP_SW_SQ;
            meg_pkg::ST_SWITCH_MUL:  op = meg_pkg::DP_SW_MUL;
            meg_pkg::ST_SWITCH_LOAD: op = meg_pkg::DP_SW_LOAD;
            meg_pkg::ST_SWITCH_STEP:
            begin
                op                    = meg_pkg::DP_STEP2;
                emit_ctl.emit         = 1'b1;
                emit_ctl.points_valid = 1'b1;
                emit_ctl.done         = status.last_point;
            end
            default:
            begin
                op = meg_pkg::DP_HOLD;
            end
        endcase
    end

endmodule

// File: rtl/core/meg_datapath.sv
// meg_datapath: offsets, step terms, decision value and two shared multipliers
// computes the four mirrored points from the next offsets
// depends on meg_pkg
module meg_datapath #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11
) (
    input  logic                         clk,
    input  meg_pkg::dp_op_t              op,
    input  logic [COORD_BITS-1:0]        center_x,
    input  logic [COORD_BITS-1:0]        center_y,
    input  logic [RADIUS_BITS-1:0]       radius_x,
    input  logic [RADIUS_BITS-1:0]       radius_y,
    output meg_pkg::dp_status_t          status,
    output logic signed [COORD_BITS+1:0] east_x,
    output logic signed [COORD_BITS+1:0] west_x,
    output logic signed [COORD_BITS+1:0] south_y,
    output logic signed [COORD_BITS+1:0] north_y
);

    localparam int TB      = meg_pkg::TERM_BITS;
    localparam int PB      = meg_pkg::PROD_BITS;
    localparam int OUT_B   = COORD_BITS + 2;
    localparam int SQ_BITS = 2 * RADIUS_BITS;
    localparam int TX_SQ   = 2 * COORD_BITS + 2;
    localparam int MA_A    = (SQ_BITS > TX_SQ) ? SQ_BITS : TX_SQ;
    localparam int MIN_MA  = (meg_pkg::PROD_BITS + 1) / 2;
    localparam int MA_BITS = (MA_A > MIN_MA) ? MA_A : MIN_MA;

    logic [COORD_BITS-1:0]  cx_reg, cx_next;
    logic [COORD_BITS-1:0]  cy_reg, cy_next;
    logic [RADIUS_BITS-1:0] ry_reg, ry_next;
    logic [SQ_BITS-1:0]     rx_sq_reg, rx_sq_next;
    logic [SQ_BITS-1:0]     ry_sq_reg, ry_sq_next;
    logic [COORD_BITS-1:0]  ox_reg, ox_next;
    logic [COORD_BITS-1:0]  oy_reg, oy_next;
    logic [TB-1:0]          x_term_reg, x_term_next;
    logic [TB-1:0]          y_term_reg, y_term_next;
    logic [TB-1:0]          dec_reg, dec_next;
    logic [PB-1:0]          prod0_reg, prod0_next;
    logic [PB-1:0]          prod1_reg, prod1_next;

    logic [MA_BITS-1:0]       m0a, m0b;
    logic [2*MA_BITS-1:0]     m0_full;
    logic signed [MA_BITS:0]  m1a, m1b;
    logic signed [2*MA_BITS+1:0] m1_full;
    logic signed [MA_BITS:0]  sq_diff;

    logic [TB-1:0]          two_rx_sq, two_ry_sq, x_inc, y_dec;
    logic [TB-1:0]          rx_sq_t, ry_sq_t;
    logic                   dec_neg, dec_pos;
    logic [COORD_BITS:0]    tx;
    logic [COORD_BITS-1:0]  ym;
    logic [PB-1:0]          quarter_sum;

    // shared step terms
    assign rx_sq_t   = TB'(rx_sq_reg);
    assign ry_sq_t   = TB'(ry_sq_reg);
    assign two_rx_sq = TB'({rx_sq_reg, 1'b0});
    assign two_ry_sq = TB'({ry_sq_reg, 1'b0});
    assign x_inc     = x_term_reg + two_ry_sq;
    assign y_dec     = y_term_reg - two_rx_sq;
    assign dec_neg   = dec_reg[TB-1];
    assign dec_pos   = !dec_neg && (dec_reg != '0);
    assign tx        = {ox_reg, 1'b1};
    assign ym        = oy_reg - COORD_BITS'(1);
    assign sq_diff   = $signed({1'b0, prod1_reg[MA_BITS-1:0]})
                     - $signed({1'b0, MA_BITS'(ry_sq_reg)});
    // region 2 value in quarter units; its floor is the rounded decision
    assign quarter_sum = prod0_reg + {prod1_reg[TB-1:0], 2'b00};

    // multiplier operand selection
    always_comb
    begin
        m0a = '0;
        m0b = '0;
        m1a = '0;
        m1b = '0;
        case (op)
            meg_pkg::DP_LOAD:
            begin
                m0a = MA_BITS'(radius_x);
                m0b = MA_BITS'(radius_x);
                m1a = $signed({1'b0, MA_BITS'(radius_y)});
                m1b = $signed({1'b0, MA_BITS'(radius_y)});
            end
            meg_pkg::DP_INIT_MUL:
            begin
                m0a = MA_BITS'(rx_sq_reg);
                m0b = MA_BITS'(ry_reg);
                m1a = $signed({1'b0, MA_BITS'(rx_sq_reg)});
                m1b = $signed({1'b0, MA_BITS'(oy_reg)});
            end
            meg_pkg::DP_SW_SQ:
            begin
                m0a = MA_BITS'(tx);
                m0b = MA_BITS'(tx);
                m1a = $signed({1'b0, MA_BITS'(ym)});
                m1b = $signed({1'b0, MA_BITS'(ym)});
            end
            meg_pkg::DP_SW_MUL:
            begin
                m0a = MA_BITS'(ry_sq_reg);
                m0b = prod0_reg[MA_BITS-1:0];
                m1a = $signed({1'b0, MA_BITS'(rx_sq_reg)});
                m1b = sq_diff;
            end
            default:
            begin
                m0a = '0;
            end
        endcase
    end

    assign m0_full = m0a * m0b;
    assign m1_full = m1a * m1b;

    // next register values
    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        ry_next     = ry_reg;
        rx_sq_next  = rx_sq_reg;
        ry_sq_next  = ry_sq_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        x_term_next = x_term_reg;
        y_term_next = y_term_reg;
        dec_next    = dec_reg;
        prod0_next  = prod0_reg;
        prod1_next  = prod1_reg;
        case (op)
            meg_pkg::DP_LOAD:
            begin
                cx_next     = center_x;
                cy_next     = center_y;
                ry_next     = radius_y;
                ox_next     = '0;
                oy_next     = COORD_BITS'(radius_y);
                x_term_next = '0;
                prod0_next  = m0_full[PB-1:0];
                prod1_next  = m1_full[PB-1:0];
            end
            meg_pkg::DP_KEEP_SQ:
            begin
                rx_sq_next = prod0_reg[SQ_BITS-1:0];
                ry_sq_next = prod1_reg[SQ_BITS-1:0];
            end
            meg_pkg::DP_INIT_MUL, meg_pkg::DP_SW_SQ, meg_pkg::DP_SW_MUL:
            begin
                prod0_next = m0_full[PB-1:0];
                prod1_next = m1_full[PB-1:0];
            end
            meg_pkg::DP_INIT_FIN:
            begin
                // ry^2 - rx^2*ry + rx^2/4, with rx^2/4 truncated by the right shift
                dec_next    = ry_sq_t - prod0_reg[TB-1:0] + TB'(rx_sq_reg >> 2);
                y_term_next = {prod1_reg[TB-2:0], 1'b0};
            end
            meg_pkg::DP_SW_LOAD:
            begin
                dec_next = quarter_sum[PB-1:2];
            end
            meg_pkg::DP_STEP1:
            begin
                ox_next     = ox_reg + COORD_BITS'(1);
                x_term_next = x_inc;
                if (dec_neg)
                begin
                    dec_next = dec_reg + ry_sq_t + x_inc;
                end
                else
                begin
                    oy_next     = oy_reg - COORD_BITS'(1);
                    y_term_next = y_dec;
                    dec_next    = dec_reg + ry_sq_t + x_inc - y_dec;
                end
            end
            meg_pkg::DP_STEP2:
            begin
                oy_next     = oy_reg - COORD_BITS'(1);
                y_term_next = y_dec;
                if (dec_pos)
                begin
                    dec_next = dec_reg + rx_sq_t - y_dec;
                end
                else
                begin
                    ox_next     = ox_reg + COORD_BITS'(1);
                    x_term_next = x_inc;
                    dec_next    = dec_reg + rx_sq_t - y_dec + x_inc;
                end
            end
            default:
            begin
                dec_next = dec_reg;
            end
        endcase
    end

    // working registers, all reloaded by a start
    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        ry_reg     <= ry_next;
        rx_sq_reg  <= rx_sq_next;
        ry_sq_reg  <= ry_sq_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        x_term_reg <= x_term_next;
        y_term_reg <= y_term_next;
        dec_reg    <= dec_next;
        prod0_reg  <= prod0_next;
        prod1_reg  <= prod1_next;
    end

    // status for the controller
    assign status.term_less  = x_term_reg < y_term_reg;
    assign status.last_point = (oy_next == '0);

    // mirrored points of the next offsets
    assign east_x  = $signed(OUT_B'(cx_next) + OUT_B'(ox_next));
    assign west_x  = $signed(OUT_B'(cx_next) - OUT_B'(ox_next));
    assign south_y = $signed(OUT_B'(cy_next) + OUT_B'(oy_next));
    assign north_y = $signed(OUT_B'(cy_next) - OUT_B'(oy_next));

endmodule

// File: rtl/core/midpoint_ellipse_generator.sv
// Midpoint ellipse generator: a start item loads center and radii and, after its setup
// states, returns the mirrored points of (0, radius_y); each advance item then takes one
// region-1 or region-2 step and returns four points in the cycle after it is accepted, so
// steps run at one item per cycle while results are taken. Leaving region 1 runs the switch
// states square, multiply, load and step, as the region-2 decision value goes through the
// two shared multipliers in two registered passes before the step. A result with done_res
// set ends the ellipse; advancing after that returns points_valid low and zero coordinates.
// A new item is taken only in an idle state, when the result register is empty or being
// read in the same cycle. Depends on meg_pkg, meg_if, meg_ctrl and meg_datapath.
module midpoint_ellipse_generator #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    meg_item_if.sink    item,
    meg_result_if.source result
);

    localparam int OUT_B = COORD_BITS + 2;

    logic                 in_ready;
    logic                 in_fire;
    logic                 idle;
    meg_pkg::dp_op_t      op;
    meg_pkg::emit_ctl_t   emit_ctl;
    meg_pkg::dp_status_t  status;

    logic signed [OUT_B-1:0] east_x, west_x, south_y, north_y;

    logic                    out_valid_reg, out_valid_next;
    logic                    points_valid_reg;
    logic                    done_reg;
    logic signed [OUT_B-1:0] east_x_reg, west_x_reg, south_y_reg, north_y_reg;

    // input transfer
    assign in_ready   = idle && (!out_valid_reg || result.ready);
    assign in_fire    = item.valid && in_ready;
    assign item.ready = in_ready;

    meg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_opcode(item.opcode),
        .status   (status),
        .idle     (idle),
        .op       (op),
        .emit_ctl (emit_ctl)
    );

    meg_datapath #(
        .COORD_BITS (COORD_BITS),
        .RADIUS_BITS(RADIUS_BITS)
    ) u_datapath (
        .clk     (clk),
        .op      (op),
        .center_x(item.center_x),
        .center_y(item.center_y),
        .radius_x(item.radius_x),
        .radius_y(item.radius_y),
        .status  (status),
        .east_x  (east_x),
        .west_x  (west_x),
        .south_y (south_y),
        .north_y (north_y)
    );

    // result register valid
    assign out_valid_next = emit_ctl.emit || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (emit_ctl.emit)
        begin
            points_valid_reg <= emit_ctl.points_valid;
            done_reg         <= emit_ctl.done;
            east_x_reg       <= emit_ctl.points_valid ? east_x : '0;
            west_x_reg       <= emit_ctl.points_valid ? west_x : '0;
            south_y_reg      <= emit_ctl.points_valid ? south_y : '0;
            north_y_reg      <= emit_ctl.points_valid ? north_y : '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.east_south_x = east_x_reg;
    assign result.east_south_y = south_y_reg;
    assign result.west_south_x = west_x_reg;
    assign result.west_south_y = south_y_reg;
    assign result.east_north_x = east_x_reg;
    assign result.east_north_y = north_y_reg;
    assign result.west_north_x = west_x_reg;
    assign result.west_north_y = north_y_reg;
    assign result.points_valid = points_valid_reg;
    assign result.done_res     = done_reg;

    // a new result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_ctl.emit |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten while full");

    // a start needs setup cycles before its first points
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && item.opcode == meg_pkg::OP_START) |=> !emit_ctl.emit)
        else $error("start produced a result too early");

    // a result without points only reports completion
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.points_valid) |-> result.done_res)
        else $error("empty result without done");

    // a result without points carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.points_valid) |->
            (result.east_south_x == '0 && result.east_south_y == '0
             && result.west_north_x == '0 && result.west_north_y == '0))
        else $error("empty result with nonzero coordinates");

endmodule
